[hdl/orrb_pkg.sv]
// Shared types and constants for the overwriting record ring buffer.
// Used by the front end, back end and top level; depends on nothing.
`timescale 1ns / 1ps

package orrb_pkg;

  // Field widths of the external items.
  localparam int unsigned PosW   = 12;
  localparam int unsigned CountW = 9;
  localparam int unsigned FreeW  = 13;
  localparam int unsigned LenW   = 16;

  // Operation codes.
  localparam logic OpPush  = 1'b0;
  localparam logic OpClear = 1'b1;

  // One input item.
  typedef struct packed {
    logic            operation;
    logic            first_byte;
    logic [LenW-1:0] record_length;
    logic [7:0]      data_byte;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [PosW-1:0]   record_start;
    logic [PosW-1:0]   oldest_start;
    logic [CountW-1:0] records_held;
    logic [FreeW-1:0]  free_bytes;
    logic [CountW-1:0] evicted_now;
    logic              byte_dropped;
  } out_item_t;

  // Classification made by the front end.
  typedef enum logic [1:0] {
    KindClear,
    KindStart,
    KindByte,
    KindZero
  } kind_e;

  // Command passed through the queue to the back end.
  typedef struct packed {
    kind_e           kind;
    logic [LenW-1:0] wlen;
    logic [7:0]      data;
  } cmd_t;

  // Back end sequencer states.
  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StEvChk,
    StHdrRd,
    StEvUpd,
    StZFill,
    StHdrWr,
    StData,
    StResult
  } back_state_e;

endpackage

[hdl/orrb_ram.sv]
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module orrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hdl/orrb_front.sv]
// Front end: classifies input items and queues them for the back end.
// Depends on orrb_pkg.
`timescale 1ns / 1ps

module orrb_front #(
  parameter int unsigned CAPACITY_BYTES = 4096,
  parameter int unsigned HEADER_BYTES   = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  orrb_pkg::in_item_t in_item_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output orrb_pkg::cmd_t    cmd_o
);

  localparam int unsigned MaxLen = CAPACITY_BYTES - HEADER_BYTES;

  orrb_pkg::cmd_t cmd_in;
  orrb_pkg::cmd_t fifo_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  logic           push, pop;

  // Classify the incoming item and truncate its length.
  always_comb begin
    cmd_in.data = in_item_i.data_byte;
    if (32'(in_item_i.record_length) > MaxLen) begin
      cmd_in.wlen = orrb_pkg::LenW'(MaxLen);
    end else begin
      cmd_in.wlen = in_item_i.record_length;
    end
    if (in_item_i.operation == orrb_pkg::OpClear) begin
      cmd_in.kind = orrb_pkg::KindClear;
    end else if (in_item_i.first_byte) begin
      cmd_in.kind = (in_item_i.record_length == '0) ? orrb_pkg::KindZero
                                                    : orrb_pkg::KindStart;
    end else begin
      cmd_in.kind = orrb_pkg::KindByte;
    end
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rp_q];

  // Two-entry queue pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= cmd_in;
    end
  end

endmodule

[hdl/orrb_back.sv]
// Back end: sequences ring clears, evictions, tail fill, header and byte writes on the ring.
// Depends on orrb_pkg and orrb_ram.
`timescale 1ns / 1ps

module orrb_back #(
  parameter int unsigned CAPACITY_BYTES = 4096,
  parameter int unsigned HEADER_BYTES   = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  orrb_pkg::cmd_t       cmd_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output orrb_pkg::out_item_t  res_o
);

  localparam int unsigned AW  = $clog2(CAPACITY_BYTES);
  localparam int unsigned LW  = $clog2(CAPACITY_BYTES + 1);
  localparam int unsigned SW  = LW + 1;
  localparam int unsigned HCW = $clog2(HEADER_BYTES + 1);
  localparam int unsigned MaxLen = CAPACITY_BYTES - HEADER_BYTES;

  orrb_pkg::back_state_e state_q, state_d;

  logic [AW-1:0]  wr_q, wr_d, old_q, old_d, bptr_q, bptr_d, hdr_q, hdr_d;
  logic [AW-1:0]  start_q, start_d, idx_q, idx_d, base_q, base_d, next_q, next_d;
  logic [LW-1:0]  cnt_q, cnt_d, left_q, left_d, ev_q, ev_d, wlen_q, wlen_d;
  logic [LW-1:0]  need_q, need_d;
  logic [SW-1:0]  claim_q, claim_d;
  logic           wrap_q, wrap_d, drop_q, drop_d, resp_q, resp_d, mode_q, mode_d;
  logic [HCW-1:0] hc_q, hc_d;
  logic [63:0]    acc_q, acc_d;
  logic [7:0]     data_q, data_d;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [7:0]     ram_wdata, ram_rdata;

  logic [LW-1:0]  free_now, size_now, wlen_in;
  logic [SW-1:0]  sum, need_in;
  logic [AW:0]    rsum;

  orrb_ram #(
    .WIDTH (8),
    .DEPTH (CAPACITY_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Free space between the write position and the oldest record.
  always_comb begin
    if (cnt_q == '0) begin
      free_now = LW'(CAPACITY_BYTES);
    end else if (old_q >= wr_q) begin
      free_now = LW'(old_q - wr_q);
    end else begin
      free_now = LW'(CAPACITY_BYTES) - LW'(wr_q) + LW'(old_q);
    end
  end

  // Truncated payload size from the gathered header bytes.
  assign size_now = (acc_q > 64'(MaxLen)) ? LW'(MaxLen) : LW'(acc_q);
  assign wlen_in  = LW'(cmd_i.wlen);
  assign need_in  = SW'(HEADER_BYTES) + SW'(wlen_in);

  // Header read address: highest byte first, wrapping round the ring.
  always_comb begin
    rsum = (AW+1)'(base_q) + (AW+1)'(HEADER_BYTES - 1) - (AW+1)'(hc_q);
    if (rsum >= (AW+1)'(CAPACITY_BYTES)) begin
      rsum = rsum - (AW+1)'(CAPACITY_BYTES);
    end
    ram_raddr = AW'(rsum);
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    wr_d = wr_q;   old_d = old_q;   bptr_d = bptr_q; hdr_d = hdr_q;
    start_d = start_q; idx_d = idx_q; base_d = base_q; next_d = next_q;
    cnt_d = cnt_q; left_d = left_q; ev_d = ev_q; wlen_d = wlen_q; need_d = need_q;
    claim_d = claim_q; wrap_d = wrap_q; drop_d = drop_q; resp_d = resp_q;
    mode_d = mode_q; hc_d = hc_q; acc_d = acc_q; data_d = data_q;
    ram_we = 1'b0; ram_waddr = idx_q; ram_wdata = 8'd0;
    cmd_ready_o = 1'b0;
    res_valid_o = 1'b0;
    sum = '0;

    case (state_q)
      // Zero the ring one byte a cycle.
      orrb_pkg::StClear: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        idx_d     = idx_q + AW'(1);
        if (idx_q == AW'(CAPACITY_BYTES - 1)) begin
          state_d = resp_q ? orrb_pkg::StResult : orrb_pkg::StIdle;
        end
      end

      orrb_pkg::StIdle: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          ev_d   = '0;
          drop_d = 1'b0;
          case (cmd_i.kind)
            orrb_pkg::KindClear: begin
              wr_d = '0; old_d = '0; bptr_d = '0; hdr_d = '0;
              cnt_d = '0; left_d = '0; idx_d = '0;
              resp_d  = 1'b1;
              state_d = orrb_pkg::StClear;
            end
            orrb_pkg::KindZero: begin
              drop_d  = 1'b1;
              state_d = orrb_pkg::StResult;
            end
            orrb_pkg::KindByte: begin
              if (left_q != '0) begin
                ram_we    = 1'b1;
                ram_waddr = bptr_q;
                ram_wdata = cmd_i.data;
                bptr_d    = (bptr_q == AW'(CAPACITY_BYTES - 1)) ? '0 : bptr_q + AW'(1);
                left_d    = left_q - LW'(1);
              end else begin
                drop_d = 1'b1;
              end
              state_d = orrb_pkg::StResult;
            end
            orrb_pkg::KindStart: begin
              wlen_d  = wlen_in;
              need_d  = LW'(need_in);
              data_d  = cmd_i.data;
              start_d = wr_q;
              sum     = SW'(wr_q) + need_in;
              wrap_d  = sum > SW'(CAPACITY_BYTES);
              claim_d = wrap_d ? SW'(CAPACITY_BYTES) - SW'(wr_q) + need_in : need_in;
              state_d = orrb_pkg::StEvChk;
            end
            default: state_d = orrb_pkg::StIdle;
          endcase
        end
      end

      // Evict while the claim exceeds the free space.
      orrb_pkg::StEvChk: begin
        if (cnt_q != '0 && claim_q > SW'(free_now)) begin
          base_d  = old_q;
          mode_d  = 1'b0;
          hc_d    = '0;
          acc_d   = '0;
          state_d = orrb_pkg::StHdrRd;
        end else if (wrap_q) begin
          idx_d   = start_q;
          state_d = orrb_pkg::StZFill;
        end else begin
          hc_d    = '0;
          state_d = orrb_pkg::StHdrWr;
        end
      end

      // Gather a header one byte a cycle, each byte from the registered read of the previous address.
      orrb_pkg::StHdrRd: begin
        if (hc_q != HCW'(0)) begin
          acc_d = {acc_q[55:0], ram_rdata};
        end
        hc_d = hc_q + HCW'(1);
        if (hc_q == HCW'(HEADER_BYTES)) begin
          if (!mode_q) begin
            state_d = orrb_pkg::StEvUpd;
          end else begin
            old_d   = (acc_d == 64'd0) ? '0 : next_q;
            state_d = orrb_pkg::StEvChk;
          end
        end
      end

      // Step the oldest position past the evicted record.
      orrb_pkg::StEvUpd: begin
        sum = SW'(old_q) + SW'(HEADER_BYTES) + SW'(size_now);
        if (sum >= SW'(CAPACITY_BYTES)) begin
          sum = sum - SW'(CAPACITY_BYTES);
        end
        cnt_d = cnt_q - LW'(1);
        ev_d  = ev_q + LW'(1);
        if (cnt_d == '0) begin
          old_d   = AW'(sum);
          state_d = orrb_pkg::StEvChk;
        end else if (sum > SW'(CAPACITY_BYTES - HEADER_BYTES - 1)) begin
          old_d   = '0;
          state_d = orrb_pkg::StEvChk;
        end else begin
          next_d  = AW'(sum);
          base_d  = AW'(sum);
          mode_d  = 1'b1;
          hc_d    = '0;
          acc_d   = '0;
          state_d = orrb_pkg::StHdrRd;
        end
      end

      // Zero the skipped tail up to the end of the ring.
      orrb_pkg::StZFill: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        idx_d     = idx_q + AW'(1);
        if (idx_q == AW'(CAPACITY_BYTES - 1)) begin
          start_d = '0;
          hc_d    = '0;
          state_d = orrb_pkg::StHdrWr;
        end
      end

      // Write the length header, least significant byte first.
      orrb_pkg::StHdrWr: begin
        ram_we    = 1'b1;
        ram_waddr = start_q + AW'(hc_q);
        ram_wdata = 8'(64'(wlen_q) >> {hc_q, 3'b000});
        hc_d      = hc_q + HCW'(1);
        if (hc_q == HCW'(HEADER_BYTES - 1)) begin
          state_d = orrb_pkg::StData;
        end
      end

      // Store the first payload byte and commit the record.
      orrb_pkg::StData: begin
        ram_we    = 1'b1;
        ram_waddr = start_q + AW'(HEADER_BYTES);
        ram_wdata = data_q;
        if (cnt_q == '0) begin
          old_d = start_q;
        end
        cnt_d = cnt_q + LW'(1);
        hdr_d = start_q;
        sum   = SW'(start_q) + SW'(need_q);
        wr_d  = (sum == SW'(CAPACITY_BYTES)) ? '0 : AW'(sum);
        sum   = SW'(start_q) + SW'(HEADER_BYTES + 1);
        bptr_d  = (sum == SW'(CAPACITY_BYTES)) ? '0 : AW'(sum);
        left_d  = wlen_q - LW'(1);
        state_d = orrb_pkg::StResult;
      end

      orrb_pkg::StResult: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          resp_d  = 1'b0;
          state_d = orrb_pkg::StIdle;
        end
      end

      default: state_d = orrb_pkg::StIdle;
    endcase
  end

  // Result fields from the committed state.
  always_comb begin
    res_o.record_start = orrb_pkg::PosW'(hdr_q);
    res_o.oldest_start = orrb_pkg::PosW'(old_q);
    res_o.records_held = orrb_pkg::CountW'(cnt_q);
    res_o.free_bytes   = orrb_pkg::FreeW'(free_now);
    res_o.evicted_now  = orrb_pkg::CountW'(ev_q);
    res_o.byte_dropped = drop_q;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= orrb_pkg::StClear;
      wr_q <= '0; old_q <= '0; bptr_q <= '0; hdr_q <= '0;
      cnt_q <= '0; left_q <= '0; ev_q <= '0; idx_q <= '0;
      drop_q <= 1'b0; resp_q <= 1'b0; hc_q <= '0;
    end else begin
      state_q <= state_d;
      wr_q <= wr_d; old_q <= old_d; bptr_q <= bptr_d; hdr_q <= hdr_d;
      cnt_q <= cnt_d; left_q <= left_d; ev_q <= ev_d; idx_q <= idx_d;
      drop_q <= drop_d; resp_q <= resp_d; hc_q <= hc_d;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk_i) begin
    start_q <= start_d; base_q <= base_d; next_q <= next_d;
    wlen_q <= wlen_d; need_q <= need_d; claim_q <= claim_d; wrap_q <= wrap_d;
    mode_q <= mode_d; acc_q <= acc_d; data_q <= data_d;
  end

endmodule

[hdl/overwriting_record_ring_buffer.sv]
// Top level of the overwriting record ring buffer.
// Depends on orrb_pkg, orrb_front, orrb_back and orrb_ram.
//
// Usage: items enter on in_valid_i/in_stall_o carrying in_item_i and are
// taken at an edge with valid high and stall low. Each item gives exactly
// one result on out_valid_o/out_stall_i carrying out_item_o.
// A two-entry queue sits behind the input, so up to two items are taken while
// the back end is busy. A payload byte is written in the idle state and its
// result goes through the result state to the output register. A record
// start passes the eviction check, per evicted record a header read and an
// oldest-position step (then a read of the next header when it is checked),
// a zero fill of any skipped tail, the header write, the first byte write and
// the result state; header bytes are read one at a time from the ring RAM.
// A clear zeroes the ring before its result; after reset the ring is zeroed
// and queued items wait until that pass ends. When the receiver stalls the
// result holds in the output register, the back end waits on its next
// result, and the input stalls once the queue is full.
`timescale 1ns / 1ps

module overwriting_record_ring_buffer #(
  parameter int unsigned CAPACITY_BYTES = 4096,
  parameter int unsigned HEADER_BYTES   = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  orrb_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output orrb_pkg::out_item_t out_item_o
);

  orrb_pkg::cmd_t      cmd;
  logic                cmd_valid, cmd_ready;
  orrb_pkg::out_item_t res;
  logic                res_valid, res_ready;
  logic                out_valid_q;
  orrb_pkg::out_item_t out_item_q;

  orrb_front #(
    .CAPACITY_BYTES (CAPACITY_BYTES),
    .HEADER_BYTES   (HEADER_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  orrb_back #(
    .CAPACITY_BYTES (CAPACITY_BYTES),
    .HEADER_BYTES   (HEADER_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: loads when empty or when its item is being taken.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[verif/tb_overwriting_record_ring_buffer.sv]
// Self-checking testbench for the overwriting record ring buffer.
// Depends on orrb_pkg and overwriting_record_ring_buffer, which brings in the rest of the design.
`timescale 1ns / 1ps

module tb_overwriting_record_ring_buffer;

  localparam int Cap      = 4096;
  localparam int Hdr      = 8;
  localparam int MaxLen   = Cap - Hdr;
  localparam int CycLimit = 3000000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  orrb_pkg::in_item_t  in_item_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  orrb_pkg::out_item_t out_item_o;

  overwriting_record_ring_buffer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  // Queues of items waiting to be sent and results still to arrive.
  orrb_pkg::in_item_t  pending_items[$];
  orrb_pkg::out_item_t expected_results[$];

  int  mismatches = 0;
  int  cycles = 0;
  int  records_sent = 0;
  int  evictions_seen = 0;
  int  results_seen = 0;
  bit  tx_idle_mode = 0;
  bit  rx_stall_mode = 0;
  bit  long_hold = 0;
  int  hold_cycles = 0;
  bit  item_taken = 0;

  // Predictor state: shadow copy of the ring and its pointers.
  logic [7:0] ring_shadow[Cap];
  int wr_pos, oldest_pos, rec_count, bytes_left, byte_ptr, cur_header;

  function automatic void clear_shadow();
    for (int i = 0; i < Cap; i++) ring_shadow[i] = 8'h00;
    wr_pos = 0; oldest_pos = 0; rec_count = 0;
    bytes_left = 0; byte_ptr = 0; cur_header = 0;
  endfunction

  // Payload length held in the header at a position, clamped to the maximum.
  function automatic longint header_len_at(int pos);
    longint size;
    size = 0;
    for (int i = 0; i < Hdr; i++)
      size |= longint'(ring_shadow[(pos + i) % Cap]) << (8 * i);
    if (size > MaxLen) size = MaxLen;
    return size;
  endfunction

  function automatic int free_space();
    if (rec_count == 0) return Cap;
    return (oldest_pos + Cap - wr_pos) % Cap;
  endfunction

  function automatic void drop_oldest();
    int nxt;
    nxt = (oldest_pos + Hdr + int'(header_len_at(oldest_pos))) % Cap;
    if (rec_count > 0) rec_count--;
    if (rec_count != 0 && ((Cap - nxt) < Hdr + 1 || header_len_at(nxt) == 0)) nxt = 0;
    oldest_pos = nxt;
  endfunction

  // Works out the result of one accepted item and updates the shadow state.
  function automatic orrb_pkg::out_item_t ring_after_item(orrb_pkg::in_item_t it);
    orrb_pkg::out_item_t r;
    int evicted, dropped, wlen, needed, start, claim;
    bit wraps;
    evicted = 0; dropped = 0;
    if (it.operation == orrb_pkg::OpClear) begin
      clear_shadow();
    end else if (it.first_byte) begin
      if (it.record_length == 0) begin
        dropped = 1;
      end else begin
        wlen = (int'(it.record_length) > MaxLen) ? MaxLen : int'(it.record_length);
        needed = Hdr + wlen;
        start = wr_pos;
        wraps = (start + needed) > Cap;
        claim = wraps ? (Cap - start) + needed : needed;
        while (rec_count > 0 && claim > free_space()) begin
          drop_oldest();
          evicted++;
        end
        if (wraps) begin
          for (int i = start; i < Cap; i++) ring_shadow[i] = 8'h00;
          start = 0;
        end
        for (int i = 0; i < Hdr; i++) ring_shadow[(start + i) % Cap] = 8'((wlen >> (8 * i)));
        ring_shadow[(start + Hdr) % Cap] = it.data_byte;
        if (rec_count == 0) oldest_pos = start;
        rec_count++;
        cur_header = start;
        wr_pos = (start + needed) % Cap;
        byte_ptr = (start + Hdr + 1) % Cap;
        bytes_left = wlen - 1;
      end
    end else if (bytes_left > 0) begin
      ring_shadow[byte_ptr] = it.data_byte;
      byte_ptr = (byte_ptr + 1) % Cap;
      bytes_left--;
    end else begin
      dropped = 1;
    end
    r.record_start = orrb_pkg::PosW'(cur_header);
    r.oldest_start = orrb_pkg::PosW'(oldest_pos);
    r.records_held = orrb_pkg::CountW'(rec_count);
    r.free_bytes   = orrb_pkg::FreeW'(free_space());
    r.evicted_now  = orrb_pkg::CountW'(evicted);
    r.byte_dropped = 1'(dropped);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    mismatches++;
  endtask

  // Item builders for the stimulus.
  function automatic orrb_pkg::in_item_t mk_item(logic op, logic first, int len, int data);
    orrb_pkg::in_item_t it;
    it.operation = op;
    it.first_byte = first;
    it.record_length = orrb_pkg::LenW'(len);
    it.data_byte = 8'(data);
    return it;
  endfunction

  // Queues a record start and the given number of its payload bytes.
  task automatic push_record(int len, int bytes);
    pending_items.push_back(mk_item(orrb_pkg::OpPush, 1'b1, len, $urandom));
    for (int i = 1; i < bytes; i++)
      pending_items.push_back(mk_item(orrb_pkg::OpPush, 1'b0, $urandom, $urandom));
    records_sent++;
  endtask

  // Mostly well-formed records of random size, with noise, broken records and clears.
  task automatic push_random(int count);
    int target, sel, len;
    target = pending_items.size() + count;
    while (pending_items.size() < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        len = $urandom_range(1, 24);
        push_record(len, len);
      end else if (sel < 78) begin
        // Large allocation cut short by the next record.
        len = $urandom_range(200, 3000);
        push_record(len, $urandom_range(1, 6));
      end else if (sel < 82) begin
        len = $urandom_range(MaxLen, 65535);
        push_record(len, $urandom_range(1, 4));
      end else if (sel < 90) begin
        pending_items.push_back(mk_item(orrb_pkg::OpPush, 1'b0, $urandom, $urandom));
      end else if (sel < 96) begin
        pending_items.push_back(mk_item(orrb_pkg::OpPush, 1'b1, 0, $urandom));
      end else if (sel < 98) begin
        pending_items.push_back(mk_item(orrb_pkg::OpPush, 1'($urandom), $urandom, $urandom));
      end else begin
        pending_items.push_back(mk_item(orrb_pkg::OpClear, 1'($urandom), $urandom, $urandom));
      end
    end
  endtask

  // Waits for all pending items to be sent and all results to arrive.
  task automatic drain();
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  // Acceptance of items and checking of results at the rising edge.
  always @(posedge clk_i) begin
    orrb_pkg::out_item_t want;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_results.push_back(ring_after_item(in_item_i));
      item_taken = 1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = expected_results.pop_front();
        evictions_seen += int'(want.evicted_now);
        if (out_item_o.record_start != want.record_start)
          report_mismatch("record_start", out_item_o.record_start, want.record_start);
        if (out_item_o.oldest_start != want.oldest_start)
          report_mismatch("oldest_start", out_item_o.oldest_start, want.oldest_start);
        if (out_item_o.records_held != want.records_held)
          report_mismatch("records_held", out_item_o.records_held, want.records_held);
        if (out_item_o.free_bytes != want.free_bytes)
          report_mismatch("free_bytes", out_item_o.free_bytes, want.free_bytes);
        if (out_item_o.evicted_now != want.evicted_now)
          report_mismatch("evicted_now", out_item_o.evicted_now, want.evicted_now);
        if (out_item_o.byte_dropped != want.byte_dropped)
          report_mismatch("byte_dropped", out_item_o.byte_dropped, want.byte_dropped);
      end
    end
  end

  // Driver: presents the next item at the falling edge, holding it until taken.
  always @(negedge clk_i) begin
    logic               nxt_valid;
    orrb_pkg::in_item_t nxt_item;
    nxt_valid = in_valid_i;
    nxt_item = in_item_i;
    if (item_taken) begin
      nxt_valid = 1'b0;
      item_taken = 0;
    end
    if (!nxt_valid && rst_ni && pending_items.size() != 0 &&
        !(tx_idle_mode && $urandom_range(0, 99) < 77)) begin
      nxt_item = pending_items.pop_front();
      nxt_valid = 1'b1;
    end
    in_valid_i <= nxt_valid;
    in_item_i <= nxt_item;
  end

  // Receiver stall, with a long counted hold-off on request.
  always @(negedge clk_i) begin
    if (long_hold && hold_cycles < 3000) begin
      hold_cycles++;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= rx_stall_mode && ($urandom_range(0, 99) < 77);
    end
  end

  // Cycle limit.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycLimit) begin
      $display("overwriting_record_ring_buffer: mismatch");
      $finish;
    end
  end

  initial begin
    clear_shadow();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: extremes, zero length, truncation, stray bytes, clear.
    pending_items.push_back(mk_item(orrb_pkg::OpPush, 1'b0, 0, 8'hFF));
    pending_items.push_back(mk_item(orrb_pkg::OpPush, 1'b1, 0, 8'h00));
    push_record(1, 1);
    push_record(3, 3);
    pending_items.push_back(mk_item(orrb_pkg::OpPush, 1'b0, 16'hFFFF, 8'h00));
    push_record(MaxLen, 2);
    push_record(MaxLen + 1, 2);
    push_record(65535, 2);
    pending_items.push_back(mk_item(orrb_pkg::OpPush, 1'b1, 0, 8'hA5));
    pending_items.push_back(mk_item(orrb_pkg::OpPush, 1'b0, 0, 8'h5A));
    push_record(2000, 1);
    push_record(2500, 1);
    push_record(16'h5555, 1);
    push_record(16'hAAAA, 1);
    pending_items.push_back(mk_item(orrb_pkg::OpClear, 1'b1, 16'hFFFF, 8'hFF));
    push_record(5, 5);
    drain();

    // Random phases with different idling patterns.
    push_random(240); drain();
    tx_idle_mode = 1; push_random(240); drain();
    tx_idle_mode = 0; rx_stall_mode = 1; push_random(240); drain();
    tx_idle_mode = 1; push_random(240); drain();
    tx_idle_mode = 0; rx_stall_mode = 0;
    long_hold = 1; push_random(240); drain();

    repeat (100) @(posedge clk_i);
    $display("Run covered %0d record starts, %0d results and %0d evictions,",
             records_sent, results_seen, evictions_seen);
    $display("under free flow, sender gaps, receiver stalls and a long receiver hold-off.");
    if (mismatches == 0) begin
      $display("overwriting_record_ring_buffer: match");
    end else begin
      $display("overwriting_record_ring_buffer: mismatch");
    end
    $finish;
  end

endmodule

[overwriting_record_ring_buffer.f]
hdl/orrb_pkg.sv
hdl/orrb_ram.sv
hdl/orrb_front.sv
hdl/orrb_back.sv
hdl/overwriting_record_ring_buffer.sv
verif/tb_overwriting_record_ring_buffer.sv
